// ===== rtl/bme_pkg.sv =====
`timescale 1ns / 1ps

package bme_pkg;

    // Serial unit widths
    localparam int DIVIDEND_W = 64;
    localparam int DIVISOR_W  = 16;
    localparam int RADICAND_W = 64;
    localparam int ROOT_W     = 32;

    // Fixed field widths
    localparam int CNT_W   = 16;
    localparam int ACC_W   = 47;
    localparam int S1_W    = 47;
    localparam int S2_W    = 45;
    localparam int MEAN_W  = 31;
    localparam int ERR_W   = 30;

    // Register map: index taken from paddr[2]
    localparam logic REG_SAMPLES_PER_BLOCK = 1'b0;
    localparam logic REG_NUM_BLOCKS        = 1'b1;

    localparam logic [CNT_W-1:0] SPB_RESET = 16'd1000;
    localparam logic [CNT_W-1:0] NB_RESET  = 16'd100;

    typedef struct packed {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;
        logic [DIVISOR_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic                  done;
        logic [DIVIDEND_W-1:0] quotient;
    } div_rsp_t;

    typedef struct packed {
        logic                  start;
        logic [RADICAND_W-1:0] radicand;
    } sqrt_req_t;

    typedef struct packed {
        logic              done;
        logic [ROOT_W-1:0] root;
    } sqrt_rsp_t;

endpackage

// ===== rtl/blocked_mean_and_error.sv =====
`timescale 1ns / 1ps

// Blocked mean and statistical error.
// Sample channel: sample with sample_valid / sample_stall; an item is taken
// at an edge where valid is high and stall is low. Each sample adds
// (x - 0.5)^2 in Q0.32 to the current block.
// Result channel: block_number, running_mean, running_error, all_done with
// result_valid / result_stall; one item per completed block.
// Sample handling: a sample that does not close a block is accepted with the
// squaring multiply, then accumulated. A block-closing sample then runs four
// divisions on the shared bit-serial divider plus a square root (two
// divisions for the first block, which skips variance and root) before its
// result item is loaded; sample_stall holds off further samples meanwhile.
// Once num_blocks blocks are done, samples are still taken, with no stall,
// and dropped. A finished result sits in the output register; a stalled
// receiver only holds up the block pipeline when the next block result is
// ready to load. Reset: all sums and counters clear, samples_per_block =
// 1000, num_blocks = 100. Config via APB at 0x0 and 0x4; the user must write
// it only when idle, which the block itself does not enforce.
module blocked_mean_and_error
    import bme_pkg::*;
#(
    parameter int SAMPLE_BITS = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // sample channel
    input  logic                   sample_valid,
    output logic                   sample_stall,
    input  logic [SAMPLE_BITS-1:0] sample,
    // result channel
    output logic                   result_valid,
    input  logic                   result_stall,
    output logic [CNT_W-1:0]       block_number,
    output logic [MEAN_W-1:0]      running_mean,
    output logic [ERR_W-1:0]       running_error,
    output logic                   all_done,
    // APB config
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [2:0]             paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    localparam int SHL = (2 * SAMPLE_BITS <= 32) ? 32 - 2 * SAMPLE_BITS : 0;
    localparam int SHR = (2 * SAMPLE_BITS > 32) ? 2 * SAMPLE_BITS - 32 : 0;
    localparam logic [SAMPLE_BITS-1:0] HALF = SAMPLE_BITS'(1) << (SAMPLE_BITS - 1);

    // sequencer
    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_ACC       = 4'd1;
    localparam logic [3:0] S_AVG_DIV   = 4'd2;
    localparam logic [3:0] S_AVG_LL    = 4'd3;
    localparam logic [3:0] S_AVG_LH    = 4'd4;
    localparam logic [3:0] S_S2        = 4'd5;
    localparam logic [3:0] S_MEAN_DIV  = 4'd6;
    localparam logic [3:0] S_MSQ       = 4'd7;
    localparam logic [3:0] S_S2C_DIV   = 4'd8;
    localparam logic [3:0] S_VAR_START = 4'd9;
    localparam logic [3:0] S_VAR_DIV   = 4'd10;
    localparam logic [3:0] S_SQRT      = 4'd11;
    localparam logic [3:0] S_OUT       = 4'd12;

    logic [3:0]       state_reg;
    logic [3:0]       state_next;

    // config
    logic [CNT_W-1:0] spb_reg;
    logic [CNT_W-1:0] nb_reg;

    // running state
    logic [CNT_W-1:0] sib_reg;
    logic [ACC_W-1:0] acc_reg;
    logic [CNT_W-1:0] bd_reg;
    logic [S1_W-1:0]  s1_reg;
    logic [S2_W-1:0]  s2_reg;

    // block working registers
    logic [ACC_W-1:0]  avg_reg;
    logic [31:0]       hi_reg;
    logic [MEAN_W-1:0] mean_reg;
    logic [ERR_W-1:0]  var_reg;
    logic [ERR_W-1:0]  err_reg;
    logic [63:0]       prod_reg;

    // output register
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [CNT_W-1:0]  out_bn_reg;
    logic [MEAN_W-1:0] out_mean_reg;
    logic [ERR_W-1:0]  out_err_reg;
    logic              out_done_reg;

    logic                   wr_en;
    logic                   accept;
    logic                   run_over;
    logic [SAMPLE_BITS-1:0] mag;
    logic [31:0]            mul_a;
    logic [31:0]            mul_b;
    logic                   mul_en;
    logic [63:0]            dev2_wide;
    logic [ACC_W-1:0]       acc_sum;
    logic [CNT_W-1:0]       sib_next;
    logic                   blk_end;
    logic [CNT_W-1:0]       blk_n;
    logic [CNT_W-1:0]       c_val;
    logic [31:0]            sq_hi;
    logic [S2_W-1:0]        var_diff;
    logic                   out_load;

    div_req_t  div_req;
    div_rsp_t  div_rsp;
    sqrt_req_t sqrt_req;
    sqrt_rsp_t sqrt_rsp;

    bme_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    bme_isqrt u_isqrt
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (sqrt_req),
        .rsp   (sqrt_rsp)
    );

    // ---------------- config port ----------------
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_comb
    begin
        unique case (paddr[2])
            REG_SAMPLES_PER_BLOCK: prdata = {16'd0, spb_reg};
            REG_NUM_BLOCKS:        prdata = {16'd0, nb_reg};
            default:               prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spb_reg <= SPB_RESET;
            nb_reg  <= NB_RESET;
        end
        else if (wr_en)
        begin
            if (paddr[2] == REG_SAMPLES_PER_BLOCK)
            begin
                spb_reg <= pwdata[CNT_W-1:0];
            end
            else
            begin
                nb_reg <= pwdata[CNT_W-1:0];
            end
        end
    end

    // ---------------- sample path ----------------
    assign sample_stall = (state_reg != S_IDLE);
    assign accept       = sample_valid && !sample_stall;
    assign run_over     = (bd_reg >= nb_reg);

    assign mag = (sample >= HALF) ? (sample - HALF) : (HALF - sample);

    // |x - 0.5|^2 scaled to Q0.32; at most 2^30
    assign dev2_wide = (prod_reg << SHL) >> SHR;
    assign acc_sum   = acc_reg + ACC_W'(dev2_wide[30:0]);
    assign sib_next  = sib_reg + 1'b1;
    assign blk_end   = (sib_next == '0) || (sib_next >= spb_reg);
    assign blk_n     = (sib_next == '0) ? CNT_W'(1) : sib_next;

    // c: completed blocks, a wrapped count counts as one
    assign c_val = (bd_reg == '0) ? CNT_W'(1) : bd_reg;

    // shared 32x32 multiplier, result registered
    always_comb
    begin
        mul_en = 1'b0;
        mul_a  = 32'(mag);
        mul_b  = 32'(mag);
        unique case (state_reg)
            S_IDLE:
            begin
                mul_en = 1'b1;
            end
            S_AVG_LL:
            begin
                mul_en = 1'b1;
                mul_a  = avg_reg[31:0];
                mul_b  = avg_reg[31:0];
            end
            S_AVG_LH:
            begin
                mul_en = 1'b1;
                mul_a  = avg_reg[31:0];
                mul_b  = 32'(avg_reg[ACC_W-1:32]);
            end
            S_MSQ:
            begin
                mul_en = 1'b1;
                mul_a  = 32'(mean_reg);
                mul_b  = 32'(mean_reg);
            end
            default:
            begin
                mul_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mul_en)
        begin
            prod_reg <= mul_a * mul_b;
        end
    end

    // bits 63:32 of avg^2 mod 2^64: al^2 high word plus twice al*ah
    assign sq_hi = hi_reg + {prod_reg[30:0], 1'b0};

    // variance before clamping
    assign var_diff = (div_rsp.quotient[S2_W-1:0] > S2_W'(prod_reg[63:32]))
                    ? div_rsp.quotient[S2_W-1:0] - S2_W'(prod_reg[63:32])
                    : '0;

    // divider and root requests
    always_comb
    begin
        div_req.start    = 1'b0;
        div_req.dividend = '0;
        div_req.divisor  = c_val;
        unique case (state_reg)
            S_ACC:
            begin
                div_req.start    = blk_end;
                div_req.dividend = DIVIDEND_W'(acc_sum);
                div_req.divisor  = blk_n;
            end
            S_S2:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = DIVIDEND_W'(s1_reg);
            end
            S_MSQ:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = DIVIDEND_W'(s2_reg);
            end
            S_VAR_START:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = {2'b00, var_reg, 32'd0};
                div_req.divisor  = c_val - 1'b1;
            end
            default:
            begin
                div_req.start = 1'b0;
            end
        endcase
    end

    assign sqrt_req.start    = (state_reg == S_VAR_DIV) && div_rsp.done;
    assign sqrt_req.radicand = div_rsp.quotient;

    assign out_load = (state_reg == S_OUT) && (!out_valid_reg || !result_stall);

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:      if (accept && !run_over) state_next = S_ACC;
            S_ACC:       state_next = blk_end ? S_AVG_DIV : S_IDLE;
            S_AVG_DIV:   if (div_rsp.done) state_next = S_AVG_LL;
            S_AVG_LL:    state_next = S_AVG_LH;
            S_AVG_LH:    state_next = S_S2;
            S_S2:        state_next = S_MEAN_DIV;
            S_MEAN_DIV:
            begin
                if (div_rsp.done)
                begin
                    state_next = (c_val > CNT_W'(1)) ? S_MSQ : S_OUT;
                end
            end
            S_MSQ:       state_next = S_S2C_DIV;
            S_S2C_DIV:   if (div_rsp.done) state_next = S_VAR_START;
            S_VAR_START: state_next = S_VAR_DIV;
            S_VAR_DIV:   if (div_rsp.done) state_next = S_SQRT;
            S_SQRT:      if (sqrt_rsp.done) state_next = S_OUT;
            S_OUT:       if (out_load) state_next = S_IDLE;
            default:     state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            sib_reg   <= '0;
            acc_reg   <= '0;
            bd_reg    <= '0;
            s1_reg    <= '0;
            s2_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_ACC)
            begin
                if (blk_end)
                begin
                    sib_reg <= '0;
                    acc_reg <= '0;
                end
                else
                begin
                    sib_reg <= sib_next;
                    acc_reg <= acc_sum;
                end
            end
            if ((state_reg == S_AVG_DIV) && div_rsp.done)
            begin
                bd_reg <= bd_reg + 1'b1;
                s1_reg <= s1_reg + div_rsp.quotient[S1_W-1:0];
            end
            if (state_reg == S_S2)
            begin
                s2_reg <= s2_reg + S2_W'(sq_hi);
            end
        end
    end

    // block working registers
    always_ff @(posedge clk)
    begin
        if ((state_reg == S_AVG_DIV) && div_rsp.done)
        begin
            avg_reg <= div_rsp.quotient[ACC_W-1:0];
        end
        if (state_reg == S_AVG_LH)
        begin
            hi_reg <= prod_reg[63:32];
        end
        if ((state_reg == S_MEAN_DIV) && div_rsp.done)
        begin
            mean_reg <= (div_rsp.quotient > DIVIDEND_W'({MEAN_W{1'b1}}))
                      ? {MEAN_W{1'b1}} : div_rsp.quotient[MEAN_W-1:0];
            err_reg  <= '0;
        end
        if ((state_reg == S_S2C_DIV) && div_rsp.done)
        begin
            var_reg <= (var_diff > S2_W'({ERR_W{1'b1}}))
                     ? {ERR_W{1'b1}} : var_diff[ERR_W-1:0];
        end
        if ((state_reg == S_SQRT) && sqrt_rsp.done)
        begin
            err_reg <= (sqrt_rsp.root > ROOT_W'({ERR_W{1'b1}}))
                     ? {ERR_W{1'b1}} : sqrt_rsp.root[ERR_W-1:0];
        end
    end

    // ---------------- result register ----------------
    always_comb
    begin
        priority if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_bn_reg   <= bd_reg;
            out_mean_reg <= mean_reg;
            out_err_reg  <= err_reg;
            out_done_reg <= (bd_reg == nb_reg);
        end
    end

    assign result_valid  = out_valid_reg;
    assign block_number  = out_bn_reg;
    assign running_mean  = out_mean_reg;
    assign running_error = out_err_reg;
    assign all_done      = out_done_reg;

endmodule

// ===== rtl/bme_div.sv =====
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle. Divisor must be non-zero.
module bme_div
    import bme_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    localparam int CNT_BITS = $clog2(DIVIDEND_W);

    logic                  running_reg;
    logic                  done_reg;
    logic [CNT_BITS-1:0]   cnt_reg;
    logic [DIVISOR_W-1:0]  rem_reg;
    logic [DIVISOR_W-1:0]  dsr_reg;
    logic [DIVIDEND_W-1:0] quo_reg;

    logic [DIVISOR_W:0]    trial;
    logic                  ge;
    logic [DIVISOR_W:0]    diff;

    assign trial = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign ge    = (trial >= {1'b0, dsr_reg});
    assign diff  = trial - {1'b0, dsr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg <= 1'b0;
            done_reg    <= 1'b0;
            cnt_reg     <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                running_reg <= 1'b1;
                cnt_reg     <= '0;
            end
            else if (running_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_BITS'(DIVIDEND_W - 1))
                begin
                    running_reg <= 1'b0;
                    done_reg    <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= '0;
            dsr_reg <= req.divisor;
            quo_reg <= req.dividend;
        end
        else if (running_reg)
        begin
            rem_reg <= ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
            quo_reg <= {quo_reg[DIVIDEND_W-2:0], ge};
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

// ===== rtl/bme_isqrt.sv =====
`timescale 1ns / 1ps

// Digit-by-digit integer square root, two radicand bits per cycle.
module bme_isqrt
    import bme_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  sqrt_req_t req,
    output sqrt_rsp_t rsp
);

    localparam int CNT_BITS = $clog2(ROOT_W);
    localparam int REM_W    = ROOT_W + 2;

    logic                  running_reg;
    logic                  done_reg;
    logic [CNT_BITS-1:0]   cnt_reg;
    logic [RADICAND_W-1:0] rad_reg;
    logic [REM_W-1:0]      rem_reg;
    logic [ROOT_W-1:0]     root_reg;

    logic [REM_W+1:0]      r;
    logic [REM_W+1:0]      trial;
    logic                  ge;
    logic [REM_W+1:0]      diff;

    assign r     = {rem_reg, rad_reg[RADICAND_W-1 -: 2]};
    assign trial = {2'b00, root_reg, 2'b01};
    assign ge    = (r >= trial);
    assign diff  = r - trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg <= 1'b0;
            done_reg    <= 1'b0;
            cnt_reg     <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                running_reg <= 1'b1;
                cnt_reg     <= '0;
            end
            else if (running_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_BITS'(ROOT_W - 1))
                begin
                    running_reg <= 1'b0;
                    done_reg    <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rad_reg  <= req.radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (running_reg)
        begin
            rad_reg  <= {rad_reg[RADICAND_W-3:0], 2'b00};
            rem_reg  <= ge ? diff[REM_W-1:0] : r[REM_W-1:0];
            root_reg <= {root_reg[ROOT_W-2:0], ge};
        end
    end

    assign rsp.done = done_reg;
    assign rsp.root = root_reg;

endmodule
